// ===== src/fpsc_pkg.sv =====
// shared widths, codes and polynomial coefficients for the sine/cosine pipeline
package fpsc_pkg;

    // field and datapath widths
    localparam int ANGLE_W     = 24;
    localparam int VALUE_W     = 26;
    localparam int FRAC_W      = 24;
    localparam int X_W         = 23;  // folded angle, 0 .. 2^22
    localparam int SQ_W        = 2 * X_W;
    localparam int X2_W        = 21;  // rounded square, 0 .. 2^20
    localparam int ACC_W       = 32;  // horner accumulator, signed
    localparam int PROD_W      = ACC_W + X2_W + 1;
    localparam int RND_W       = PROD_W - FRAC_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int NCOEF       = 6;

    // function select carried in tuser
    localparam logic MODE_COS = 1'b0;
    localparam logic MODE_SIN = 1'b1;

    // quadrant taken from the top two angle bits
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // fold points in turns, one sign bit above the angle
    localparam logic signed [ANGLE_W:0] TURN_QUARTER  = 25'sd4194304;
    localparam logic signed [ANGLE_W:0] TURN_HALF     = 25'sd8388608;
    localparam logic signed [ANGLE_W:0] TURN_3QUARTER = 25'sd12582912;
    localparam logic signed [ANGLE_W:0] TURN_FULL     = 25'sd16777216;

    // rounding offset for the shift by FRAC_W
    localparam logic [SQ_W-1:0]   SQ_HALF   = SQ_W'(1) << (FRAC_W - 1);
    localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_W - 1);

    // horner coefficients, highest power first, 8.24 truncated toward zero
    localparam logic signed [ACC_W-1:0] COEF [NCOEF] = '{
        -32'sd443359018,
         32'sd1010737361,
        -32'sd1433727479,
         32'sd1089502240,
        -32'sd331168969,
         32'sd16777216
    };

endpackage

// ===== src/fixed_point_sine_cosine_top.sv =====
// top level of the pipelined fixed-point sine/cosine unit
//
// slave stream: i_s_tdata carries the angle in turns (2^24 is one turn),
// i_s_tuser selects the function (0 cosine, 1 sine). a transfer happens when
// i_s_tvalid and o_s_tready are both high.
// master stream: o_m_tdata carries the signed 2.24 result in its low 26 bits,
// upper bits zero. a transfer happens when o_m_tvalid and i_m_tready are high.
// the path from input transfer to o_m_tvalid runs through one fold stage, two
// squaring stages, two stages for each of the five horner steps and one output
// register. throughput is one item per cycle while the receiver takes results;
// each stage holds one item and the stage count sets the latency.
// every stage loads when it is empty or its successor moves, so bubbles close
// up and a stalled receiver fills the pipeline before o_s_tready drops; nothing
// is dropped or repeated while stalled.
// reset (i_rst_n low, synchronous) clears all stage valids; no data is kept.
module fixed_point_sine_cosine_top
    import fpsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [23:0] angle
    input  logic                   i_s_tuser,   // [0] mode
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [25:0] value, [31:26] zero
);

    localparam int NSTEP = NCOEF - 1;

    logic                    fold_valid;
    logic                    fold_ready;
    logic [X_W-1:0]          fold_x;
    logic                    fold_neg;
    logic                    sq_valid;
    logic                    sq_ready;
    logic [X2_W-1:0]         sq_x2;
    logic                    sq_neg;

    // horner chain, index 0 is the entry
    logic                    h_valid [NSTEP+1];
    logic                    h_ready [NSTEP+1];
    logic signed [ACC_W-1:0] h_acc   [NSTEP+1];
    logic [X2_W-1:0]         h_x2    [NSTEP+1];
    logic                    h_neg   [NSTEP+1];

    logic                    r_out_valid;
    logic [VALUE_W-1:0]      r_out_value;
    logic signed [ACC_W-1:0] n_signed;
    logic                    out_ready;

    // quadrant fold
    fpsc_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_angle (i_s_tdata[ANGLE_W-1:0]),
        .i_mode  (i_s_tuser),
        .o_valid (fold_valid),
        .i_ready (fold_ready),
        .o_x     (fold_x),
        .o_neg   (fold_neg)
    );

    // square of the folded angle
    fpsc_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fold_valid),
        .o_ready (fold_ready),
        .i_x     (fold_x),
        .i_neg   (fold_neg),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_x2    (sq_x2),
        .o_neg   (sq_neg)
    );

    // horner entry starts from the leading coefficient
    assign h_valid[0] = sq_valid;
    assign sq_ready   = h_ready[0];
    assign h_acc[0]   = COEF[0];
    assign h_x2[0]    = sq_x2;
    assign h_neg[0]   = sq_neg;

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        fpsc_horner u_horner (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (h_valid[k]),
            .o_ready (h_ready[k]),
            .i_acc   (h_acc[k]),
            .i_x2    (h_x2[k]),
            .i_neg   (h_neg[k]),
            .i_coef  (COEF[k+1]),
            .o_valid (h_valid[k+1]),
            .i_ready (h_ready[k+1]),
            .o_acc   (h_acc[k+1]),
            .o_x2    (h_x2[k+1]),
            .o_neg   (h_neg[k+1])
        );
    end

    // output register with sign applied
    assign out_ready       = !r_out_valid || i_m_tready;
    assign h_ready[NSTEP]  = out_ready;
    assign n_signed        = h_neg[NSTEP] ? -h_acc[NSTEP] : h_acc[NSTEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= h_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && h_valid[NSTEP]) begin
            r_out_value <= n_signed[VALUE_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - VALUE_W){1'b0}}, r_out_value};

    // an empty output register opens the whole chain to new input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked while output register is empty");

    // a taking receiver always lets a new item in
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input blocked while receiver is ready");

endmodule

// ===== src/fpsc_fold.sv =====
// quadrant fold stage: reduces the angle to a quarter turn and records the sign
module fpsc_fold
    import fpsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [ANGLE_W-1:0] i_angle,
    input  logic               i_mode,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [X_W-1:0]     o_x,
    output logic               o_neg
);

    logic                      r_valid;
    logic [X_W-1:0]            r_x;
    logic                      r_neg;
    logic signed [ANGLE_W:0]   a_ext;
    logic signed [ANGLE_W:0]   fold;
    logic                      n_neg;
    t_quad                     quad;

    assign o_ready = !r_valid || i_ready;
    assign a_ext   = {1'b0, i_angle};
    assign quad    = t_quad'(i_angle[ANGLE_W-1 -: 2]);

    // fold per quadrant and function
    always_comb begin
        fold  = a_ext;
        n_neg = 1'b0;
        if (i_mode == MODE_COS) begin
            unique case (quad)
                QUAD_0: begin fold = a_ext;                n_neg = 1'b0; end
                QUAD_1: begin fold = TURN_HALF - a_ext;    n_neg = 1'b1; end
                QUAD_2: begin fold = a_ext - TURN_HALF;    n_neg = 1'b1; end
                QUAD_3: begin fold = TURN_FULL - a_ext;    n_neg = 1'b0; end
                default: begin fold = a_ext;               n_neg = 1'b0; end
            endcase
        end else begin
            unique case (quad)
                QUAD_0: begin fold = TURN_QUARTER - a_ext;  n_neg = 1'b0; end
                QUAD_1: begin fold = a_ext - TURN_QUARTER;  n_neg = 1'b0; end
                QUAD_2: begin fold = TURN_3QUARTER - a_ext; n_neg = 1'b1; end
                QUAD_3: begin fold = a_ext - TURN_3QUARTER; n_neg = 1'b1; end
                default: begin fold = a_ext;                n_neg = 1'b0; end
            endcase
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x   <= fold[X_W-1:0];
            r_neg <= n_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_neg   = r_neg;

endmodule

// ===== src/fpsc_square.sv =====
// squaring unit: multiply stage then round stage
module fpsc_square
    import fpsc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [X_W-1:0]  i_x,
    input  logic            i_neg,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [X2_W-1:0] o_x2,
    output logic            o_neg
);

    logic                   r_valid_m;
    logic                   r_valid_r;
    logic [SQ_W-1:0]        r_prod;
    logic                   r_neg_m;
    logic [X2_W-1:0]        r_x2;
    logic                   r_neg_r;
    logic [SQ_W-1:0]        n_prod;
    logic [SQ_W-1:0]        sum;
    logic                   ready_r;
    logic                   ready_m;

    assign ready_r = !r_valid_r || i_ready;
    assign ready_m = !r_valid_m || ready_r;
    assign o_ready = ready_m;

    // exact square and round to nearest
    assign n_prod = SQ_W'(i_x) * SQ_W'(i_x);
    assign sum    = r_prod + SQ_HALF;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_m <= 1'b0;
            r_valid_r <= 1'b0;
        end else begin
            if (ready_m) begin
                r_valid_m <= i_valid;
            end
            if (ready_r) begin
                r_valid_r <= r_valid_m;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (ready_m && i_valid) begin
            r_prod  <= n_prod;
            r_neg_m <= i_neg;
        end
        if (ready_r && r_valid_m) begin
            r_x2    <= sum[FRAC_W +: X2_W];
            r_neg_r <= r_neg_m;
        end
    end

    assign o_valid = r_valid_r;
    assign o_x2    = r_x2;
    assign o_neg   = r_neg_r;

endmodule

// ===== src/fpsc_horner.sv =====
// one horner step: acc * x2 in a multiply stage, round and add coefficient next
module fpsc_horner
    import fpsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic [X2_W-1:0]         i_x2,
    input  logic                    i_neg,
    input  logic signed [ACC_W-1:0] i_coef,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [ACC_W-1:0] o_acc,
    output logic [X2_W-1:0]         o_x2,
    output logic                    o_neg
);

    logic                    r_valid_m;
    logic                    r_valid_a;
    logic [PROD_W-1:0]       r_prod;
    logic [X2_W-1:0]         r_x2_m;
    logic                    r_neg_m;
    logic signed [ACC_W-1:0] r_acc;
    logic [X2_W-1:0]         r_x2_a;
    logic                    r_neg_a;
    logic [PROD_W-1:0]       acc_ext;
    logic [PROD_W-1:0]       x2_ext;
    logic [PROD_W-1:0]       n_prod;
    logic [PROD_W-1:0]       sum;
    logic [RND_W-1:0]        rnd;
    logic signed [ACC_W-1:0] n_acc;
    logic                    ready_a;
    logic                    ready_m;

    assign ready_a = !r_valid_a || i_ready;
    assign ready_m = !r_valid_m || ready_a;
    assign o_ready = ready_m;

    // two's complement product, low bits are exact
    assign acc_ext = {{(PROD_W - ACC_W){i_acc[ACC_W-1]}}, i_acc};
    assign x2_ext  = {{(PROD_W - X2_W){1'b0}}, i_x2};
    assign n_prod  = acc_ext * x2_ext;

    // round to nearest, floor shift, then add the coefficient
    assign sum   = r_prod + PROD_HALF;
    assign rnd   = sum[PROD_W-1:FRAC_W];
    assign n_acc = $signed({{(ACC_W - RND_W){rnd[RND_W-1]}}, rnd}) + i_coef;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_m <= 1'b0;
            r_valid_a <= 1'b0;
        end else begin
            if (ready_m) begin
                r_valid_m <= i_valid;
            end
            if (ready_a) begin
                r_valid_a <= r_valid_m;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (ready_m && i_valid) begin
            r_prod  <= n_prod;
            r_x2_m  <= i_x2;
            r_neg_m <= i_neg;
        end
        if (ready_a && r_valid_m) begin
            r_acc   <= n_acc;
            r_x2_a  <= r_x2_m;
            r_neg_a <= r_neg_m;
        end
    end

    assign o_valid = r_valid_a;
    assign o_acc   = r_acc;
    assign o_x2    = r_x2_a;
    assign o_neg   = r_neg_a;

endmodule

// ===== tb/fixed_point_sine_cosine_checker.sv =====
// stream checker for the sine/cosine unit: predicts each result and compares it
module fixed_point_sine_cosine_checker
    import fpsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [23:0] angle
    input  logic                   i_s_tuser,   // [0] mode
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // [25:0] value, [31:26] zero
    output int                     o_fail_count,
    output int                     o_pending
);

    // fold points in turns
    localparam longint QTR_TURN  = 64'sd4194304;
    localparam longint HALF_TURN = 64'sd8388608;
    localparam longint TQ_TURN   = 64'sd12582912;
    localparam longint FULL_TURN = 64'sd16777216;

    // cosine series terms in 8.24, highest power of x^2 first
    localparam longint COS_TERM [6] = '{
        -64'sd443359018,
         64'sd1010737361,
        -64'sd1433727479,
         64'sd1089502240,
        -64'sd331168969,
         64'sd16777216
    };

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic               mode;
        logic [VALUE_W-1:0] value;
    } t_trig_result;

    t_trig_result trig_expected_q[$];
    int           fail_cnt = 0;
    int           pend_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;

    // q24 product, round to nearest with ties upward
    function automatic longint q24_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 23)) >>> 24;
    endfunction

    // cos(2*pi*x) for x in a quarter turn, horner over x^2
    function automatic longint quarter_cos(longint x);
        longint x2;
        longint acc;
        x2  = q24_mul(x, x);
        acc = COS_TERM[0];
        for (int k = 1; k < 6; k++) begin
            acc = q24_mul(acc, x2) + COS_TERM[k];
        end
        return acc;
    endfunction

    // quadrant fold and sign for both functions
    function automatic logic [VALUE_W-1:0] trig_value(logic [ANGLE_W-1:0] angle, logic mode);
        longint a    = longint'(angle);
        t_quad  quad = t_quad'(angle[ANGLE_W-1:ANGLE_W-2]);
        longint r;
        if (mode == MODE_COS) begin
            case (quad)
                QUAD_0:  r = quarter_cos(a);
                QUAD_1:  r = -quarter_cos(HALF_TURN - a);
                QUAD_2:  r = -quarter_cos(a - HALF_TURN);
                default: r = quarter_cos(FULL_TURN - a);
            endcase
        end else begin
            case (quad)
                QUAD_0:  r = quarter_cos(QTR_TURN - a);
                QUAD_1:  r = quarter_cos(a - QTR_TURN);
                QUAD_2:  r = -quarter_cos(TQ_TURN - a);
                default: r = -quarter_cos(a - TQ_TURN);
            endcase
        end
        return r[VALUE_W-1:0];
    endfunction

    // watch both channels at the clock edge
    always @(posedge i_clk) begin : watch
        t_trig_result want;
        if (i_rst_n) begin
            // result transfer against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (trig_expected_q.size() == 0) begin
                    $error("unexpected result transfer: value %0d",
                           $signed(i_m_tdata[VALUE_W-1:0]));
                    fail_cnt++;
                end else begin
                    want = trig_expected_q.pop_front();
                    if (i_m_tdata[VALUE_W-1:0] !== want.value) begin
                        $error("value (angle %h mode %0d): expected %0d, actual %0d",
                               want.angle, want.mode, $signed(want.value),
                               $signed(i_m_tdata[VALUE_W-1:0]));
                        fail_cnt++;
                    end
                    if (i_m_tdata[OUT_TDATA_W-1:VALUE_W] !== '0) begin
                        $error("pad bits: expected 0, actual %h",
                               i_m_tdata[OUT_TDATA_W-1:VALUE_W]);
                        fail_cnt++;
                    end
                end
            end
            // input transfer produces one prediction
            if (i_s_tvalid && i_s_tready) begin
                want.angle = i_s_tdata[ANGLE_W-1:0];
                want.mode  = i_s_tuser;
                want.value = trig_value(want.angle, want.mode);
                trig_expected_q.push_back(want);
            end
        end
        pend_cnt = trig_expected_q.size();
    end

endmodule

// ===== tb/tb_fixed_point_sine_cosine_top.sv =====
// testbench top for the sine/cosine unit: clock, reset, stimulus and verdict
module tb_fixed_point_sine_cosine_top
    import fpsc_pkg::*;
;

    localparam int NUM_RANDOM  = 1300;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     fail_count;
    int                     pending;
    int                     idle_cycles = 0;
    bit                     tx_burst = 1'b0;
    bit                     rx_burst = 1'b0;

    // clock, period 4
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    fixed_point_sine_cosine_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    fixed_point_sine_cosine_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one angle transfer, with a random gap in front; starts and ends at a falling edge
    task automatic send_angle(input logic [ANGLE_W-1:0] angle, input logic mode);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        s_tuser  <= mode;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    // hold off the sender until the pipeline has drained
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // receiver: random stall before each result transfer
    initial begin : receiver
        int unsigned hold;
        int unsigned taken;
        taken    = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            hold = rx_burst ? 0 : $urandom_range(0, 12);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            @(negedge clk);
            taken++;
            if (taken % 64 == 0) begin
                rx_burst = ($urandom_range(0, 2) == 0);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [ANGLE_W-1:0] corner [13];
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] base;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_COS;

        // quadrant edges, neighbors and field extremes
        corner = '{24'h000000, 24'h000001, 24'h3FFFFF, 24'h400000, 24'h400001,
                   24'h7FFFFF, 24'h800000, 24'h800001, 24'hBFFFFF, 24'hC00000,
                   24'hC00001, 24'hFFFFFF, 24'hAAAAAA};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, both functions at the first twelve corner angles, sine only at the last
        for (int i = 0; i < 12; i++) begin
            send_angle(corner[i], MODE_COS);
            send_angle(corner[i], MODE_SIN);
        end
        send_angle(corner[12], MODE_SIN);
        drain_pipeline();

        // random part
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 100 == 0) begin
                tx_burst = ($urandom_range(0, 2) == 0);
            end
            if (n == 450 || n == 900) begin
                drain_pipeline();
            end
            case ($urandom_range(0, 3))
                0, 1: angle = ANGLE_W'($urandom);
                2: begin
                    // close to a quadrant boundary, either side
                    base  = {2'($urandom_range(0, 3)), 22'd0};
                    angle = base + ANGLE_W'($urandom_range(0, 16)) - ANGLE_W'(8);
                end
                default: begin
                    // small offset inside a random quadrant
                    base  = {2'($urandom_range(0, 3)), 22'd0};
                    angle = base | ANGLE_W'($urandom_range(0, 1023));
                end
            endcase
            send_angle(angle, 1'($urandom_range(0, 1)));
        end

        // wait for the last results, then a few more cycles for strays
        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
